### design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define SCP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

// Value must be unchanged from the previous cycle whenever the antecedent holds.
`define SCP_ASSERT_HOLD(lbl, clk, rst, ante, sig) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> $stable(sig)) \
      else $error("value moved while held");

`endif

### design/scp_pkg.sv
package scp_pkg;

   localparam int SUBVERTEX_SHIFT = 1;
   // zoom*32 shifted by 8+precision
   localparam int SCALE_SHIFT = 5 + 8 + SUBVERTEX_SHIFT;
   localparam int U_STEP_SHIFT = 17;

   localparam int DIV_NUM_W = 25;
   localparam int DIV_DEN_W = 17;
   localparam int DIV_STAGES = DIV_NUM_W;
   localparam int COL_W = 17;

   localparam logic [9:0] SCREEN_WIDTH_RESET = 10'd160;
   localparam logic [9:0] CENTER_COLUMN_RESET = 10'd80;
   localparam logic [7:0] ZOOM_RESET = 8'd80;
   localparam logic [14:0] NEAR_CLIP_RESET = 15'd161;

   typedef enum logic [1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_CENTER_COLUMN = 2'd1,
      CSR_ZOOM          = 2'd2,
      CSR_NEAR_CLIP     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIV_DEN_W-1:0] rem;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_state_type;

   // sideband riding next to the projection divides
   typedef struct packed {
      logic       neg_l;
      logic       neg_r;
      logic       reject;
      logic [7:0] fw;
   } sb1_type;

   typedef struct packed {
      logic [DIV_NUM_W-1:0] mag_l;
      logic [DIV_NUM_W-1:0] mag_r;
      logic [DIV_NUM_W-1:0] mag_s;
      logic [14:0]          depth;
      sb1_type              side;
   } setup_type;

   // sideband riding next to the step divide
   typedef struct packed {
      logic signed [COL_W-1:0] xmin;
      logic signed [COL_W-1:0] xmax;
      logic [15:0]             scale;
      logic                    reject;
   } sb2_type;

   typedef struct packed {
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
      sb2_type              side;
   } span_type;

   // one restoring division step
   function automatic div_state_type div_step(input div_state_type s);
      logic [DIV_DEN_W:0] t;
      div_state_type r;
      t = {s.rem, s.num[DIV_NUM_W-1]};
      r = s;
      if (t >= {1'b0, s.den}) begin
         r.rem = DIV_DEN_W'(t - {1'b0, s.den});
         r.num = {s.num[DIV_NUM_W-2:0], 1'b1};
      end else begin
         r.rem = t[DIV_DEN_W-1:0];
         r.num = {s.num[DIV_NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // signed 16-bit saturation of a sign/magnitude quotient
   function automatic logic [15:0] sat16(input logic neg, input logic [DIV_NUM_W-1:0] mag);
      logic [15:0] r;
      if (!neg) begin
         r = (mag > DIV_NUM_W'(32767)) ? 16'h7fff : mag[15:0];
      end else begin
         r = (mag > DIV_NUM_W'(32768)) ? 16'h8000 : 16'(-mag[15:0]);
      end
      return r;
   endfunction

endpackage

### design/scp_divider.sv
// Unsigned restoring divider, one quotient bit per stage.
module scp_divider (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [scp_pkg::DIV_NUM_W-1:0]  num,
   input  logic [scp_pkg::DIV_DEN_W-1:0]  den,
   output logic [scp_pkg::DIV_NUM_W-1:0]  quo
);

   scp_pkg::div_state_type st_ff [scp_pkg::DIV_STAGES];
   scp_pkg::div_state_type st_in [scp_pkg::DIV_STAGES];

   always_comb begin
      st_in[0] = scp_pkg::div_step('{rem: '0, num: num, den: den});
      for (int k = 1; k < scp_pkg::DIV_STAGES; k++) begin
         st_in[k] = scp_pkg::div_step(st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign quo = st_ff[scp_pkg::DIV_STAGES-1].num;

endmodule

### design/scp_setup.sv
// Edge positions, projection products and near-clip test.
module scp_setup (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [15:0] req_sprite_x,
   input  logic [14:0]        req_sprite_depth,
   input  logic [7:0]         req_frame_width,
   input  logic [7:0]         req_frame_x_offset,
   input  logic [7:0]         zoom,
   input  logic [14:0]        near_clip,
   output scp_pkg::setup_type setup_ff
);

   logic [15:0]        left;
   logic [15:0]        right;
   logic signed [23:0] prod_l;
   logic signed [23:0] prod_r;
   scp_pkg::setup_type setup_in;

   always_comb begin
      left   = 16'(req_sprite_x) - (16'(req_frame_x_offset) << scp_pkg::SUBVERTEX_SHIFT);
      right  = left + (16'(req_frame_width) << scp_pkg::SUBVERTEX_SHIFT);
      prod_l = 24'($signed(left) * $signed({1'b0, zoom}));
      prod_r = 24'($signed(right) * $signed({1'b0, zoom}));

      setup_in.mag_l = scp_pkg::DIV_NUM_W'(prod_l[23] ? 24'(-prod_l) : prod_l);
      setup_in.mag_r = scp_pkg::DIV_NUM_W'(prod_r[23] ? 24'(-prod_r) : prod_r);
      setup_in.mag_s = scp_pkg::DIV_NUM_W'(zoom) << scp_pkg::SCALE_SHIFT;
      setup_in.depth = req_sprite_depth;
      setup_in.side.neg_l  = prod_l[23];
      setup_in.side.neg_r  = prod_r[23];
      setup_in.side.reject = (req_sprite_depth < near_clip) || (req_sprite_depth == 15'd0);
      setup_in.side.fw     = req_frame_width;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         setup_ff <= setup_in;
      end
   end

endmodule

### design/scp_span.sv
// Saturate edge quotients, add center, off-screen tests, step divide operands.
module scp_span (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [scp_pkg::DIV_NUM_W-1:0] quo_l,
   input  logic [scp_pkg::DIV_NUM_W-1:0] quo_r,
   input  logic [scp_pkg::DIV_NUM_W-1:0] quo_s,
   input  scp_pkg::sb1_type              side,
   input  logic [9:0]                    center_column,
   input  logic [9:0]                    screen_width,
   output scp_pkg::span_type             span_ff
);

   logic [15:0]                      sat_l;
   logic [15:0]                      sat_r;
   logic signed [scp_pkg::COL_W-1:0] xmin;
   logic signed [scp_pkg::COL_W-1:0] xmax;
   scp_pkg::span_type                span_in;

   always_comb begin
      sat_l = scp_pkg::sat16(side.neg_l, quo_l);
      sat_r = scp_pkg::sat16(side.neg_r, quo_r);
      xmin  = $signed({sat_l[15], sat_l}) + $signed({7'b0, center_column});
      xmax  = $signed({sat_r[15], sat_r}) + $signed({7'b0, center_column});

      span_in.num = scp_pkg::DIV_NUM_W'(side.fw) << scp_pkg::U_STEP_SHIFT;
      span_in.den = scp_pkg::DIV_DEN_W'({sat_r[15], sat_r} - {sat_l[15], sat_l});
      span_in.side.xmin   = xmin;
      span_in.side.xmax   = xmax;
      span_in.side.scale  = scp_pkg::sat16(1'b0, quo_s);
      span_in.side.reject = side.reject
                            || (xmax <= $signed(17'd0))
                            || (xmin >= $signed({7'b0, screen_width}))
                            || (xmin >= xmax);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         span_ff <= span_in;
      end
   end

endmodule

### design/sprite_column_projection.sv
// Channel  Direction  Beat contents
// req_     in         sprite_x, sprite_depth, frame_width, frame_x_offset
// rsp_     out        visible, start_column, span_minus_one, column_scale, u_start, u_step
// csr_     in         index, data (always ready)
//
// One beat per cycle sustained while rsp beats are taken.
// The pipe holds two ranks of 25-stage bit-per-stage dividers (edge/scale, then step).
// Synchronous active-high reset clears valid bits and loads register defaults.
// The whole pipe moves together: it stalls only while rsp holds a beat not taken.
`include "assert_macros.svh"

module sprite_column_projection (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sprite_x,
   input  logic [14:0]        req_sprite_depth,
   input  logic [7:0]         req_frame_width,
   input  logic [7:0]         req_frame_x_offset,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_visible,
   output logic [9:0]         rsp_start_column,
   output logic [9:0]         rsp_span_minus_one,
   output logic signed [15:0] rsp_column_scale,
   output logic signed [31:0] rsp_u_start,
   output logic signed [31:0] rsp_u_step,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_data
);

   // valid bit positions along the pipe
   localparam int V_S1 = 0;
   localparam int V_S2 = V_S1 + scp_pkg::DIV_STAGES + 1;
   localparam int V_S3 = V_S2 + scp_pkg::DIV_STAGES + 1;
   localparam int PIPE_DEPTH = V_S3 + 1;

   logic [9:0]  screen_width_ff;
   logic [9:0]  center_column_ff;
   logic [7:0]  zoom_ff;
   logic [14:0] near_clip_ff;

   logic                  adv;
   logic [PIPE_DEPTH-1:0] valid_ff;

   scp_pkg::setup_type setup_ff;
   scp_pkg::span_type  span_ff;
   scp_pkg::sb1_type   sb1_ff [scp_pkg::DIV_STAGES];
   scp_pkg::sb2_type   sb2_ff [scp_pkg::DIV_STAGES];

   logic [scp_pkg::DIV_NUM_W-1:0] quo_l;
   logic [scp_pkg::DIV_NUM_W-1:0] quo_r;
   logic [scp_pkg::DIV_NUM_W-1:0] quo_s;
   logic [scp_pkg::DIV_NUM_W-1:0] quo_du;

   // clip stage
   scp_pkg::sb2_type                 sb_end;
   logic [15:0]                      xmin_mag;
   logic [40:0]                      u_prod;
   logic signed [scp_pkg::COL_W-1:0] xmin_c;
   logic signed [scp_pkg::COL_W-1:0] xmax_c;
   logic                             s3_visible_in;
   logic [9:0]                       s3_start_in;
   logic [9:0]                       s3_span_in;
   logic [31:0]                      s3_u_start_in;
   logic                             s3_visible_ff;
   logic [9:0]                       s3_start_ff;
   logic [9:0]                       s3_span_ff;
   logic [15:0]                      s3_scale_ff;
   logic [31:0]                      s3_u_start_ff;
   logic [31:0]                      s3_u_step_ff;

   logic        rsp_valid_ff;
   logic        rsp_visible_ff;
   logic [9:0]  rsp_start_ff;
   logic [9:0]  rsp_span_ff;
   logic [15:0] rsp_scale_ff;
   logic [31:0] rsp_u_start_ff;
   logic [31:0] rsp_u_step_ff;

   // ---------------- config registers ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= scp_pkg::SCREEN_WIDTH_RESET;
         center_column_ff <= scp_pkg::CENTER_COLUMN_RESET;
         zoom_ff          <= scp_pkg::ZOOM_RESET;
         near_clip_ff     <= scp_pkg::NEAR_CLIP_RESET;
      end else if (csr_valid) begin
         unique case (scp_pkg::csr_index_type'(csr_index))
            scp_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data[9:0];
            scp_pkg::CSR_CENTER_COLUMN: center_column_ff <= csr_data[9:0];
            scp_pkg::CSR_ZOOM:          zoom_ff          <= csr_data[7:0];
            scp_pkg::CSR_NEAR_CLIP:     near_clip_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- pipe control ----------------
   // Global advance: everything moves when the output slot is free or drained.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // ---------------- stage 1: edges, products ----------------
   scp_setup u_setup (
      .clock              (clock),
      .adv                (adv),
      .req_sprite_x       (req_sprite_x),
      .req_sprite_depth   (req_sprite_depth),
      .req_frame_width    (req_frame_width),
      .req_frame_x_offset (req_frame_x_offset),
      .zoom               (zoom_ff),
      .near_clip          (near_clip_ff),
      .setup_ff           (setup_ff)
   );

   // ---------------- projection divides by depth ----------------
   scp_divider u_div_l (
      .clock (clock), .adv (adv),
      .num   (setup_ff.mag_l),
      .den   (scp_pkg::DIV_DEN_W'(setup_ff.depth)),
      .quo   (quo_l)
   );

   scp_divider u_div_r (
      .clock (clock), .adv (adv),
      .num   (setup_ff.mag_r),
      .den   (scp_pkg::DIV_DEN_W'(setup_ff.depth)),
      .quo   (quo_r)
   );

   scp_divider u_div_s (
      .clock (clock), .adv (adv),
      .num   (setup_ff.mag_s),
      .den   (scp_pkg::DIV_DEN_W'(setup_ff.depth)),
      .quo   (quo_s)
   );

   // signs, reject and width follow the divides
   always_ff @(posedge clock) begin
      if (adv) begin
         sb1_ff[0] <= setup_ff.side;
         for (int k = 1; k < scp_pkg::DIV_STAGES; k++) begin
            sb1_ff[k] <= sb1_ff[k-1];
         end
      end
   end

   // ---------------- stage 2: columns, screen tests ----------------
   scp_span u_span (
      .clock         (clock),
      .adv           (adv),
      .quo_l         (quo_l),
      .quo_r         (quo_r),
      .quo_s         (quo_s),
      .side          (sb1_ff[scp_pkg::DIV_STAGES-1]),
      .center_column (center_column_ff),
      .screen_width  (screen_width_ff),
      .span_ff       (span_ff)
   );

   // ---------------- texture step divide ----------------
   // den is zero only for sprites already rejected; the quotient is then unused.
   scp_divider u_div_du (
      .clock (clock), .adv (adv),
      .num   (span_ff.num),
      .den   (span_ff.den),
      .quo   (quo_du)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sb2_ff[0] <= span_ff.side;
         for (int k = 1; k < scp_pkg::DIV_STAGES; k++) begin
            sb2_ff[k] <= sb2_ff[k-1];
         end
      end
   end

   // ---------------- stage 3: left/right clip, start coordinate ----------------
   always_comb begin
      sb_end   = sb2_ff[scp_pkg::DIV_STAGES-1];
      // xmin >= -32768 here, so its magnitude fits 16 bits
      xmin_mag = 16'(-sb_end.xmin);
      u_prod   = 41'(quo_du) * 41'(xmin_mag);
      // (-du) * xmin == du * |xmin| mod 2^32 when xmin is negative
      s3_u_start_in = sb_end.xmin[scp_pkg::COL_W-1] ? u_prod[31:0] : 32'd0;
      xmin_c = sb_end.xmin[scp_pkg::COL_W-1] ? '0 : sb_end.xmin;
      xmax_c = (sb_end.xmax > $signed({7'b0, screen_width_ff}))
               ? $signed({7'b0, screen_width_ff}) : sb_end.xmax;
      s3_visible_in = !sb_end.reject && (xmax_c > xmin_c);
      s3_start_in   = xmin_c[9:0];
      s3_span_in    = 10'(xmax_c - xmin_c - 17'sd1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_visible_ff <= s3_visible_in;
         s3_start_ff   <= s3_start_in;
         s3_span_ff    <= s3_span_in;
         s3_scale_ff   <= sb_end.scale;
         s3_u_start_ff <= s3_u_start_in;
         s3_u_step_ff  <= 32'(quo_du);
      end
   end

   // ---------------- output register ----------------
   // Rejected sprites leave every result field at zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_ff[V_S3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_visible_ff <= s3_visible_ff;
         rsp_start_ff   <= s3_visible_ff ? s3_start_ff   : '0;
         rsp_span_ff    <= s3_visible_ff ? s3_span_ff    : '0;
         rsp_scale_ff   <= s3_visible_ff ? s3_scale_ff   : '0;
         rsp_u_start_ff <= s3_visible_ff ? s3_u_start_ff : '0;
         rsp_u_step_ff  <= s3_visible_ff ? s3_u_step_ff  : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visible        = rsp_visible_ff;
   assign rsp_start_column   = rsp_start_ff;
   assign rsp_span_minus_one = rsp_span_ff;
   assign rsp_column_scale   = $signed(rsp_scale_ff);
   assign rsp_u_start        = $signed(rsp_u_start_ff);
   assign rsp_u_step         = $signed(rsp_u_step_ff);

   // ---------------- assertions ----------------
   // A rejected beat carries zero u_start, u_step and scale fields.
   `SCP_ASSERT_IMPLY(a_reject_zero, clock, reset, rsp_valid_ff && !rsp_visible_ff, (rsp_u_start_ff == 32'd0) && (rsp_u_step_ff == 32'd0) && (rsp_scale_ff == 16'd0))
   // A visible sprite always has a nonzero texture step.
   `SCP_ASSERT_IMPLY(a_step_nonzero, clock, reset, rsp_valid_ff && rsp_visible_ff, rsp_u_step_ff != 32'd0)
   // During a stall the pipe's valid bits stay put.
   `SCP_ASSERT_HOLD(a_stall_hold, clock, reset, !$past(reset) && !$past(adv), valid_ff)

endmodule
